### rtl/core/smart_beacon_scheduler_assert.svh
// Assertion macros used by the scheduler RTL.
`ifndef SMART_BEACON_SCHEDULER_ASSERT_SVH
`define SMART_BEACON_SCHEDULER_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SBS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define SBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define SBS_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define SBS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### rtl/core/sbs_pkg.sv
package sbs_pkg;

   localparam int TIME_W     = 32;
   localparam int SPEED_W    = 12;
   localparam int TRACK_W    = 9;
   localparam int RATE_W     = 16;
   localparam int ANGLE_W    = 8;
   localparam int SLOPE_W    = 16;
   localparam int DIVIDEND_W = RATE_W + SPEED_W;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int CNT_W      = $clog2(TIME_W);
   localparam int PROD_W     = ANGLE_W + SPEED_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_W      = 16;

   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_SPEED     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_RATE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_SPEED     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_RATE      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TURN_TIME  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TURN_ANGLE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_SLOPE     = 3'd6;

   localparam logic [SPEED_W-1:0] RST_HIGH_SPEED     = 12'd960;
   localparam logic [RATE_W-1:0]  RST_FAST_RATE      = 16'd180;
   localparam logic [SPEED_W-1:0] RST_SLOW_SPEED     = 12'd80;
   localparam logic [RATE_W-1:0]  RST_SLOW_RATE      = 16'd1800;
   localparam logic [RATE_W-1:0]  RST_MIN_TURN_TIME  = 16'd15;
   localparam logic [ANGLE_W-1:0] RST_MIN_TURN_ANGLE = 8'd30;
   localparam logic [SLOPE_W-1:0] RST_TURN_SLOPE     = 16'd240;

   localparam logic [TRACK_W-1:0] DEG_FULL = 9'd360;
   localparam logic [TRACK_W-1:0] DEG_HALF = 9'd180;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } ser_ctl_type;

endpackage

### rtl/core/smart_beacon_scheduler.sv
// A request beat is accepted only in ST_IDLE; the 32-bit bit-serial elapsed-time
//   subtractor then runs in ST_RUN with the 28-step serial divider alongside it,
//   and ST_FINISH registers the result once the output is free, then returns to ST_IDLE.
// A waiting result does not block the next request beat.
// Reset (synchronous, active high) loads the default registers and clears state.
`include "smart_beacon_scheduler_assert.svh"

module smart_beacon_scheduler
   import sbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // speed_q4[11:0], track_deg[20:12], fix_time_s[52:21], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // speed_valid[0], track_valid[1], time_valid[2]
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // beacon[0], turn_trigger[1], interval_s[17:2], heading_change_deg[25:18],
   // elapsed_s[57:26], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_W - 1);
   localparam logic [CNT_W-1:0] CNT_DIV  = CNT_W'(DIV_STEPS);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [SPEED_W-1:0] high_speed_ff, high_speed_in;
   logic [RATE_W-1:0]  fast_rate_ff, fast_rate_in;
   logic [SPEED_W-1:0] slow_speed_ff, slow_speed_in;
   logic [RATE_W-1:0]  slow_rate_ff, slow_rate_in;
   logic [RATE_W-1:0]  min_turn_time_ff, min_turn_time_in;
   logic [ANGLE_W-1:0] min_turn_angle_ff, min_turn_angle_in;
   logic [SLOPE_W-1:0] turn_slope_ff, turn_slope_in;

   logic [SPEED_W-1:0] held_speed_ff, held_speed_in;
   logic [TRACK_W-1:0] held_track_ff, held_track_in;
   logic [TIME_W-1:0]  held_time_ff, held_time_in;
   logic [TIME_W-1:0]  last_beacon_ff, last_beacon_in;
   logic [TRACK_W-1:0] beacon_track_ff, beacon_track_in;
   logic               track_known_ff, track_known_in;
   logic               started_ff, started_in;

   logic [ANGLE_W-1:0] change_ff, change_in;
   logic               excess_ok_ff, excess_ok_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic accept;
   logic out_free;
   logic commit;
   ser_ctl_type sub_ctl;
   ser_ctl_type div_ctl;

   logic [TRACK_W-1:0]    track_raw;
   logic [TRACK_W-1:0]    track_mod;
   logic [DIVIDEND_W-1:0] dividend;
   logic [DIVIDEND_W-1:0] quotient;
   logic [TIME_W-1:0]     diff;
   logic                  borrow;

   logic [TRACK_W-1:0] trk_dist;
   logic [TRACK_W-1:0] trk_wrap;
   logic [ANGLE_W-1:0] change_cur;
   logic [ANGLE_W-1:0] excess;

   logic               restart;
   logic [TIME_W-1:0]  elapsed;
   logic               slow;
   logic [RATE_W-1:0]  quot_sat;
   logic [RATE_W-1:0]  interval;
   logic               turn;
   logic               fire;
   logic [ANGLE_W-1:0] change_out;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (cnt_ff == CNT_LAST) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready   = 1'b0;
      sub_ctl.load = 1'b0;
      sub_ctl.step = 1'b0;
      div_ctl.load = 1'b0;
      div_ctl.step = 1'b0;
      commit       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            sub_ctl.load = req_tvalid;
            div_ctl.load = req_tvalid;
         end
         ST_RUN: begin
            sub_ctl.step = 1'b1;
            div_ctl.step = cnt_ff < CNT_DIV;
         end
         ST_FINISH: begin
            commit = out_free;
         end
         default: ;
      endcase
   end

   assign cnt_in = (state_ff == ST_RUN) ? cnt_ff + 1'b1 : '0;

   // configuration
   always_comb begin
      high_speed_in     = high_speed_ff;
      fast_rate_in      = fast_rate_ff;
      slow_speed_in     = slow_speed_ff;
      slow_rate_in      = slow_rate_ff;
      min_turn_time_in  = min_turn_time_ff;
      min_turn_angle_in = min_turn_angle_ff;
      turn_slope_in     = turn_slope_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HIGH_SPEED:     high_speed_in     = csr_wdata[SPEED_W-1:0];
            CSR_FAST_RATE:      fast_rate_in      = csr_wdata[RATE_W-1:0];
            CSR_SLOW_SPEED:     slow_speed_in     = csr_wdata[SPEED_W-1:0];
            CSR_SLOW_RATE:      slow_rate_in      = csr_wdata[RATE_W-1:0];
            CSR_MIN_TURN_TIME:  min_turn_time_in  = csr_wdata[RATE_W-1:0];
            CSR_MIN_TURN_ANGLE: min_turn_angle_in = csr_wdata[ANGLE_W-1:0];
            CSR_TURN_SLOPE:     turn_slope_in     = csr_wdata[SLOPE_W-1:0];
            default: ;
         endcase
      end
   end

   // capture
   assign track_raw = req_tdata[20:12];
   assign track_mod = (track_raw >= DEG_FULL) ? track_raw - DEG_FULL : track_raw;

   always_comb begin
      held_speed_in = held_speed_ff;
      held_track_in = held_track_ff;
      held_time_in  = held_time_ff;
      if (accept) begin
         if (req_tuser[0]) held_speed_in = req_tdata[11:0];
         if (req_tuser[1]) held_track_in = track_mod;
         if (req_tuser[2]) held_time_in  = req_tdata[52:21];
      end
   end

   assign dividend = DIVIDEND_W'(fast_rate_ff) * DIVIDEND_W'(high_speed_ff);

   sbs_ser_sub u_sub (
      .clock      (clock),
      .ctl        (sub_ctl),
      .minuend    (held_time_in),
      .subtrahend (last_beacon_ff),
      .diff       (diff),
      .borrow     (borrow)
   );

   sbs_ser_div u_div (
      .clock    (clock),
      .ctl      (div_ctl),
      .dividend (dividend),
      .divisor  (held_speed_ff),
      .quotient (quotient)
   );

   // heading change and turn product, settled during the serial run
   always_comb begin
      trk_dist   = (held_track_ff >= beacon_track_ff) ? held_track_ff - beacon_track_ff
                                                      : beacon_track_ff - held_track_ff;
      trk_wrap   = (trk_dist > DEG_HALF) ? DEG_FULL - trk_dist : trk_dist;
      change_cur = track_known_ff ? trk_wrap[ANGLE_W-1:0] : '0;
      excess     = change_cur - min_turn_angle_ff;
      change_in    = (state_ff == ST_RUN) ? change_cur : change_ff;
      excess_ok_in = (state_ff == ST_RUN) ? (change_cur > min_turn_angle_ff) : excess_ok_ff;
      prod_in      = (state_ff == ST_RUN) ? PROD_W'(excess) * PROD_W'(held_speed_ff)
                                          : prod_ff;
   end

   // decision
   always_comb begin
      restart  = !started_ff || borrow;
      elapsed  = restart ? '0 : diff;
      slow     = (held_speed_ff == '0) || (held_speed_ff < slow_speed_ff);
      quot_sat = (|quotient[DIVIDEND_W-1:RATE_W]) ? '1 : quotient[RATE_W-1:0];
      if (slow) begin
         interval = slow_rate_ff;
      end else if (held_speed_ff > high_speed_ff) begin
         interval = fast_rate_ff;
      end else begin
         interval = quot_sat;
      end
      turn = !slow && excess_ok_ff && (prod_ff > {turn_slope_ff, 4'b0000})
             && (elapsed > TIME_W'(min_turn_time_ff));
      fire = turn || (elapsed >= TIME_W'(interval));
      change_out = slow ? '0 : change_ff;
   end

   always_comb begin
      last_beacon_in  = last_beacon_ff;
      beacon_track_in = beacon_track_ff;
      track_known_in  = track_known_ff;
      started_in      = started_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_data_in     = rsp_data_ff;
      if (commit) begin
         started_in = 1'b1;
         if (fire || restart) last_beacon_in = held_time_ff;
         if (fire || (!slow && !track_known_ff)) beacon_track_in = held_track_ff;
         if (fire || !slow) track_known_in = 1'b1;
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'b000000, elapsed, change_out, interval, turn, fire};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         cnt_ff            <= '0;
         high_speed_ff     <= RST_HIGH_SPEED;
         fast_rate_ff      <= RST_FAST_RATE;
         slow_speed_ff     <= RST_SLOW_SPEED;
         slow_rate_ff      <= RST_SLOW_RATE;
         min_turn_time_ff  <= RST_MIN_TURN_TIME;
         min_turn_angle_ff <= RST_MIN_TURN_ANGLE;
         turn_slope_ff     <= RST_TURN_SLOPE;
         held_speed_ff     <= '0;
         held_track_ff     <= '0;
         held_time_ff      <= '0;
         last_beacon_ff    <= '0;
         beacon_track_ff   <= '0;
         track_known_ff    <= 1'b0;
         started_ff        <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         cnt_ff            <= cnt_in;
         high_speed_ff     <= high_speed_in;
         fast_rate_ff      <= fast_rate_in;
         slow_speed_ff     <= slow_speed_in;
         slow_rate_ff      <= slow_rate_in;
         min_turn_time_ff  <= min_turn_time_in;
         min_turn_angle_ff <= min_turn_angle_in;
         turn_slope_ff     <= turn_slope_in;
         held_speed_ff     <= held_speed_in;
         held_track_ff     <= held_track_in;
         held_time_ff      <= held_time_in;
         last_beacon_ff    <= last_beacon_in;
         beacon_track_ff   <= beacon_track_in;
         track_known_ff    <= track_known_in;
         started_ff        <= started_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      change_ff    <= change_in;
      excess_ok_ff <= excess_ok_in;
      prod_ff      <= prod_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SBS_ASSERT_IMPLY(a_turn_fires, clock, reset, rsp_tvalid && rsp_tdata[1], rsp_tdata[0])
   `SBS_ASSERT_IMPLY(a_hdg_range, clock, reset, rsp_tvalid, rsp_tdata[25:18] <= DEG_HALF[7:0])
   `SBS_ASSERT_NEXT(a_accept_run, clock, reset, accept, state_ff == ST_RUN && cnt_ff == '0)
   `SBS_ASSERT_NEXT(a_run_end, clock, reset, state_ff == ST_RUN && cnt_ff == CNT_LAST, state_ff == ST_FINISH)
   `SBS_ASSERT_NEXT(a_commit_valid, clock, reset, commit, rsp_tvalid && state_ff == ST_IDLE)

endmodule

### rtl/core/sbs_ser_sub.sv
module sbs_ser_sub
   import sbs_pkg::*;
(
   input  logic              clock,
   input  ser_ctl_type       ctl,
   input  logic [TIME_W-1:0] minuend,
   input  logic [TIME_W-1:0] subtrahend,
   output logic [TIME_W-1:0] diff,
   output logic              borrow
);

   logic [TIME_W-1:0] a_ff, a_in;
   logic [TIME_W-1:0] b_ff, b_in;
   logic [TIME_W-1:0] d_ff, d_in;
   logic              c_ff, c_in;
   logic              bit_d;
   logic              bit_c;

   // LSB first, one bit per beat of the shift registers
   always_comb begin
      bit_d = a_ff[0] ^ b_ff[0] ^ c_ff;
      bit_c = (~a_ff[0] & b_ff[0]) | (~(a_ff[0] ^ b_ff[0]) & c_ff);
      a_in  = a_ff;
      b_in  = b_ff;
      d_in  = d_ff;
      c_in  = c_ff;
      if (ctl.load) begin
         a_in = minuend;
         b_in = subtrahend;
         c_in = 1'b0;
      end else if (ctl.step) begin
         a_in = {1'b0, a_ff[TIME_W-1:1]};
         b_in = {1'b0, b_ff[TIME_W-1:1]};
         d_in = {bit_d, d_ff[TIME_W-1:1]};
         c_in = bit_c;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      d_ff <= d_in;
      c_ff <= c_in;
   end

   assign diff   = d_ff;
   assign borrow = c_ff;

endmodule

### rtl/core/sbs_ser_div.sv
module sbs_ser_div
   import sbs_pkg::*;
(
   input  logic                  clock,
   input  ser_ctl_type           ctl,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [SPEED_W-1:0]    divisor,
   output logic [DIVIDEND_W-1:0] quotient
);

   logic [SPEED_W:0]      rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] dq_ff, dq_in;
   logic [SPEED_W:0]      rem_sh;
   logic [SPEED_W:0]      rem_dif;
   logic                  ge;

   // restoring division, one quotient bit per step
   always_comb begin
      rem_sh  = {rem_ff[SPEED_W-1:0], dq_ff[DIVIDEND_W-1]};
      ge      = rem_sh >= {1'b0, divisor};
      rem_dif = rem_sh - {1'b0, divisor};
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      if (ctl.load) begin
         rem_in = '0;
         dq_in  = dividend;
      end else if (ctl.step) begin
         rem_in = ge ? rem_dif : rem_sh;
         dq_in  = {dq_ff[DIVIDEND_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
   end

   assign quotient = dq_ff;

endmodule
